/* design/ipid_pkg.sv */
// Shared types, constants and register map of the incremental PID controller.
package ipid_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int LEVEL_W       = 10;
    localparam int GAIN_W        = 32;
    localparam int PERIOD_W      = 16;
    localparam int SCALED_W      = 12;
    localparam int ERR_W         = 13;
    localparam int SPAN_W        = 14;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W     = 16;
    localparam int OUT_FIELDS_W   = LEVEL_W + SCALED_W + ERR_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_SCALED_LSB = LEVEL_W;
    localparam int OUT_ERR_LSB    = LEVEL_W + SCALED_W;

    localparam int FULL_SCALE = 1023;
    localparam int MS_PER_S   = 1000;
    localparam int SCALED_MAX = 2047;
    localparam int SCALED_MIN = -2048;

    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_CNT_W  = 7;
    localparam int SCALE_NUM_W    = 2 * LEVEL_W + 1;
    localparam int SCALE_DIV_BITS = 20;
    localparam int DERIV_DIV_BITS = 56;

    // integral term: divide by 2000 with a reciprocal multiply, 20-bit digits
    localparam int RCP_DIGIT_W = 20;
    localparam int RCP_DIGITS  = 3;
    localparam int RCP_NUM_W   = RCP_DIGIT_W * RCP_DIGITS;
    localparam int RCP_REM_W   = 11;
    localparam int RCP_X_W     = RCP_REM_W + RCP_DIGIT_W;
    localparam int RCP_MUL_W   = 32;
    localparam int RCP_PROD_W  = RCP_X_W + RCP_MUL_W;
    localparam int RCP_SHIFT   = 42;
    localparam int RCP_CNT_W   = 2;
    // ceil(2^42 / 2000), exact for every partial dividend below 2^31
    localparam logic [RCP_MUL_W-1:0] RCP_RECIP = 32'd2199023256;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd6;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [PERIOD_W-1:0]      period_ms;
        logic [LEVEL_W-1:0]       setpoint;
        logic [LEVEL_W-1:0]       range_low;
        logic [LEVEL_W-1:0]       range_high;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        prop_gain:  32'sh0001_0000,
        integ_gain: 32'sh0001_0000,
        deriv_gain: 32'sh0001_0000,
        period_ms:  16'd10,
        setpoint:   10'd0,
        range_low:  10'd0,
        range_high: 10'd1023
    };

    typedef enum logic [2:0] {
        MUL_PROP,
        MUL_INTEG_SPAN,
        MUL_INTEG,
        MUL_DERIV_SPAN,
        MUL_DERIV
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_SCALE,
        DIV_INTEG,
        DIV_DERIV
    } div_sel_t;

    typedef struct packed {
        logic     load_sample;
        logic     scale_direct;
        logic     scale_from_div;
        logic     calc_error;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     add_prod;
        logic     add_quot;
        logic     clamp;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic range_ok;
        logic div_done;
    } sts_t;

endpackage

/* design/ipid_cfg_regs.sv */
// Configuration register file: gains, period, setpoint and input range.
module ipid_cfg_regs import ipid_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:  cfg_next.prop_gain  = $signed(cfg_wdata[GAIN_W-1:0]);
                REG_INTEG_GAIN: cfg_next.integ_gain = $signed(cfg_wdata[GAIN_W-1:0]);
                REG_DERIV_GAIN: cfg_next.deriv_gain = $signed(cfg_wdata[GAIN_W-1:0]);
                REG_PERIOD_MS:  cfg_next.period_ms  = cfg_wdata[PERIOD_W-1:0];
                REG_SETPOINT:   cfg_next.setpoint   = cfg_wdata[LEVEL_W-1:0];
                REG_RANGE_LOW:  cfg_next.range_low  = cfg_wdata[LEVEL_W-1:0];
                REG_RANGE_HIGH: cfg_next.range_high = cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/ipid_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module ipid_divider import ipid_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    input  logic [DIV_CNT_W-1:0] count,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_NUM_W-1:0] quot_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;

    logic [DIV_DEN_W:0]   rem_shift;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;

    // numerator arrives left-aligned; count is the number of significant bits
    assign rem_shift = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            num_reg  <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg  <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
            quot_reg <= {quot_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* design/ipid_datapath.sv */
// Datapath: range scaling, error, shared multiplier and divider, accumulator and clamp.
module ipid_datapath import ipid_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_t                   cmd,
    input  cfg_t                   cfg,
    input  logic [SAMPLE_W-1:0]    raw_sample,
    output sts_t                   sts,
    output logic [OUT_TDATA_W-1:0] result_data
);

    localparam int ACC_W = LEVEL_W + FRAC_BITS;
    localparam logic [ACC_W-1:0] ACC_TOP = {LEVEL_W'(FULL_SCALE), {FRAC_BITS{1'b0}}};

    logic [SAMPLE_W-1:0]        raw_reg;
    logic signed [SCALED_W-1:0] scaled_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [SPAN_W-1:0]   span_sum_reg;
    logic signed [SPAN_W-1:0]   span_dif_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   sum_reg;
    logic signed [PROD_W-1:0]   sum_next;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;
    logic                       div_neg_reg;
    logic [OUT_TDATA_W-1:0]     out_reg;

    logic                       rcp_busy_reg;
    logic                       rcp_done_reg;
    logic                       rcp_phase_reg;
    logic [RCP_CNT_W-1:0]       rcp_cnt_reg;
    logic [RCP_NUM_W-1:0]       rcp_num_reg;
    logic [RCP_REM_W-1:0]       rcp_rem_reg;
    logic [RCP_X_W-1:0]         rcp_x_reg;
    logic [RCP_PROD_W-1:0]      rcp_prod_reg;
    logic [RCP_NUM_W-1:0]       rcp_quot_reg;

    logic [PERIOD_W-1:0]           per_eff;
    logic signed [LEVEL_W:0]       span_diff;
    logic signed [SCALE_NUM_W-1:0] scale_num;
    logic [SCALE_NUM_W-1:0]        scale_mag;
    logic [PROD_W-1:0]             prod_mag;
    logic signed [ERR_W-1:0]       err_next;
    logic signed [MUL_W-1:0]       mul_a;
    logic signed [MUL_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]      mul_res;
    logic [DIV_NUM_W-1:0]          div_num;
    logic [DIV_DEN_W-1:0]          div_den;
    logic [DIV_CNT_W-1:0]          div_cnt;
    logic                          div_neg;
    logic                          div_done;
    logic [DIV_NUM_W-1:0]          div_quot;
    logic                          ser_start;
    logic                          rcp_start;
    logic [RCP_X_W-1:0]            rcp_x;
    logic [RCP_DIGIT_W-1:0]        rcp_q;
    logic [RCP_X_W-1:0]            rcp_back;
    logic [RCP_X_W-1:0]            rcp_diff;
    logic [DIV_NUM_W-1:0]          quot_mag;
    logic signed [PROD_W-1:0]      quot_s;
    logic signed [SCALED_W-1:0]    scale_sat;
    logic signed [PROD_W-1:0]      acc_top_s;

    assign per_eff = (cfg.period_ms == '0) ? PERIOD_W'(1) : cfg.period_ms;

    // 1023 * (raw - low) as (x << 10) - x
    assign span_diff = $signed({1'b0, raw_reg}) - $signed({1'b0, cfg.range_low});
    assign scale_num = (SCALE_NUM_W'(span_diff) <<< LEVEL_W) - SCALE_NUM_W'(span_diff);
    assign scale_mag = scale_num[SCALE_NUM_W-1] ? SCALE_NUM_W'(-scale_num)
                                                : SCALE_NUM_W'(scale_num);
    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    assign err_next = ERR_W'($signed({1'b0, cfg.setpoint})) - ERR_W'(scaled_reg);

    always_comb begin
        case (cmd.mul_sel)
            MUL_PROP: begin
                mul_a = cfg.prop_gain;
                mul_b = MUL_W'(err_reg);
            end
            MUL_INTEG_SPAN: begin
                mul_a = MUL_W'(span_sum_reg);
                mul_b = $signed(MUL_W'(per_eff));
            end
            MUL_INTEG: begin
                mul_a = cfg.integ_gain;
                mul_b = $signed(prod_reg[MUL_W-1:0]);
            end
            MUL_DERIV_SPAN: begin
                mul_a = MUL_W'(span_dif_reg);
                mul_b = MUL_W'(MS_PER_S);
            end
            MUL_DERIV: begin
                mul_a = cfg.deriv_gain;
                mul_b = $signed(prod_reg[MUL_W-1:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = mul_a * mul_b;

    always_comb begin
        case (cmd.div_sel)
            DIV_SCALE: begin
                div_num = {scale_mag[SCALE_DIV_BITS-1:0], {(DIV_NUM_W-SCALE_DIV_BITS){1'b0}}};
                div_den = DIV_DEN_W'(cfg.range_high - cfg.range_low);
                div_cnt = DIV_CNT_W'(SCALE_DIV_BITS);
                div_neg = scale_num[SCALE_NUM_W-1];
            end
            DIV_INTEG: begin
                div_num = '0;
                div_den = DIV_DEN_W'(1);
                div_cnt = DIV_CNT_W'(1);
                div_neg = prod_reg[PROD_W-1];
            end
            DIV_DERIV: begin
                div_num = {prod_mag[DERIV_DIV_BITS-1:0], {(DIV_NUM_W-DERIV_DIV_BITS){1'b0}}};
                div_den = DIV_DEN_W'(per_eff);
                div_cnt = DIV_CNT_W'(DERIV_DIV_BITS);
                div_neg = prod_reg[PROD_W-1];
            end
            default: begin
                div_num = '0;
                div_den = DIV_DEN_W'(1);
                div_cnt = DIV_CNT_W'(1);
                div_neg = 1'b0;
            end
        endcase
    end

    assign ser_start = cmd.div_start && (cmd.div_sel != DIV_INTEG);
    assign rcp_start = cmd.div_start && (cmd.div_sel == DIV_INTEG);

    ipid_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ser_start),
        .num     (div_num),
        .den     (div_den),
        .count   (div_cnt),
        .done    (div_done),
        .quot    (div_quot)
    );

    // divide by 2000: each 20-bit digit takes a multiply step, then a remainder step
    assign rcp_x    = {rcp_rem_reg, rcp_num_reg[RCP_NUM_W-1 -: RCP_DIGIT_W]};
    assign rcp_q    = rcp_prod_reg[RCP_SHIFT +: RCP_DIGIT_W];
    assign rcp_back = RCP_X_W'(rcp_q) * RCP_X_W'(2 * MS_PER_S);
    assign rcp_diff = rcp_x_reg - rcp_back;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcp_busy_reg  <= 1'b0;
            rcp_done_reg  <= 1'b0;
            rcp_phase_reg <= 1'b0;
            rcp_cnt_reg   <= '0;
        end else begin
            rcp_done_reg <= 1'b0;
            if (rcp_start) begin
                rcp_busy_reg  <= 1'b1;
                rcp_phase_reg <= 1'b0;
                rcp_cnt_reg   <= RCP_CNT_W'(RCP_DIGITS);
            end else if (rcp_busy_reg) begin
                rcp_phase_reg <= !rcp_phase_reg;
                if (rcp_phase_reg) begin
                    rcp_cnt_reg <= rcp_cnt_reg - RCP_CNT_W'(1);
                    if (rcp_cnt_reg == RCP_CNT_W'(1)) begin
                        rcp_busy_reg <= 1'b0;
                        rcp_done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rcp_start) begin
            rcp_num_reg  <= prod_mag[RCP_NUM_W-1:0];
            rcp_rem_reg  <= '0;
            rcp_quot_reg <= '0;
        end else if (rcp_busy_reg) begin
            if (!rcp_phase_reg) begin
                rcp_x_reg    <= rcp_x;
                rcp_prod_reg <= rcp_x * RCP_RECIP;
            end else begin
                rcp_rem_reg  <= rcp_diff[RCP_REM_W-1:0];
                rcp_quot_reg <= {rcp_quot_reg[RCP_NUM_W-RCP_DIGIT_W-1:0], rcp_q};
                rcp_num_reg  <= rcp_num_reg << RCP_DIGIT_W;
            end
        end
    end

    assign quot_mag = (cmd.div_sel == DIV_INTEG) ? DIV_NUM_W'(rcp_quot_reg) : div_quot;

    // truncation toward zero: divide magnitudes, restore the sign
    assign quot_s = div_neg_reg ? -$signed(quot_mag) : $signed(quot_mag);

    always_comb begin
        if (quot_s > SCALED_MAX) begin
            scale_sat = SCALED_W'(SCALED_MAX);
        end else if (quot_s < SCALED_MIN) begin
            scale_sat = SCALED_W'(SCALED_MIN);
        end else begin
            scale_sat = quot_s[SCALED_W-1:0];
        end
    end

    always_comb begin
        sum_next = sum_reg;
        if (cmd.calc_error) begin
            sum_next = $signed(PROD_W'(acc_reg));
        end else if (cmd.add_prod) begin
            sum_next = sum_reg + prod_reg;
        end else if (cmd.add_quot) begin
            sum_next = sum_reg + quot_s;
        end
    end

    assign acc_top_s = $signed(PROD_W'(ACC_TOP));

    always_comb begin
        if (sum_reg < 0) begin
            acc_next = '0;
        end else if (sum_reg > acc_top_s) begin
            acc_next = ACC_TOP;
        end else begin
            acc_next = sum_reg[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            acc_reg      <= '0;
        end else if (cmd.clamp) begin
            prev_err_reg <= err_reg;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            raw_reg <= raw_sample;
        end
        if (cmd.scale_direct) begin
            scaled_reg <= SCALED_W'($signed({1'b0, raw_reg}));
        end else if (cmd.scale_from_div) begin
            scaled_reg <= scale_sat;
        end
        if (cmd.calc_error) begin
            err_reg      <= err_next;
            span_sum_reg <= SPAN_W'(prev_err_reg) + SPAN_W'(err_next);
            span_dif_reg <= SPAN_W'(prev_err_reg) - SPAN_W'(err_next);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_res;
        end
        if (cmd.div_start) begin
            div_neg_reg <= div_neg;
        end
        sum_reg <= sum_next;
        if (cmd.load_out) begin
            out_reg <= OUT_TDATA_W'({err_reg, scaled_reg, acc_reg[ACC_W-1 -: LEVEL_W]});
        end
    end

    assign sts.range_ok = (cfg.range_high > cfg.range_low);
    assign sts.div_done = div_done | rcp_done_reg;
    assign result_data  = out_reg;

endmodule

/* design/ipid_ctrl.sv */
// Controller: sequences one sample through the datapath and runs the stream handshakes.
module ipid_ctrl import ipid_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [14:0] {
        ST_IDLE       = 15'b000000000000001,
        ST_SCALE      = 15'b000000000000010,
        ST_SCALE_DIV  = 15'b000000000000100,
        ST_ERROR      = 15'b000000000001000,
        ST_PROP_MUL   = 15'b000000000010000,
        ST_INTEG_SPAN = 15'b000000000100000,
        ST_INTEG_MUL  = 15'b000000001000000,
        ST_INTEG_GO   = 15'b000000010000000,
        ST_INTEG_DIV  = 15'b000000100000000,
        ST_DERIV_SPAN = 15'b000001000000000,
        ST_DERIV_MUL  = 15'b000010000000000,
        ST_DERIV_GO   = 15'b000100000000000,
        ST_DERIV_DIV  = 15'b001000000000000,
        ST_CLAMP      = 15'b010000000000000,
        ST_OUTPUT     = 15'b100000000000000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (sts.range_ok) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SCALE;
                    state_next    = ST_SCALE_DIV;
                end else begin
                    cmd.scale_direct = 1'b1;
                    state_next       = ST_ERROR;
                end
            end
            ST_SCALE_DIV: begin
                cmd.div_sel = DIV_SCALE;
                if (sts.div_done) begin
                    cmd.scale_from_div = 1'b1;
                    state_next         = ST_ERROR;
                end
            end
            ST_ERROR: begin
                cmd.calc_error = 1'b1;
                state_next     = ST_PROP_MUL;
            end
            ST_PROP_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
                state_next  = ST_INTEG_SPAN;
            end
            ST_INTEG_SPAN: begin
                // proportional term is added while the product register reloads
                cmd.add_prod = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_INTEG_SPAN;
                state_next   = ST_INTEG_MUL;
            end
            ST_INTEG_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTEG;
                state_next  = ST_INTEG_GO;
            end
            ST_INTEG_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_INTEG;
                state_next    = ST_INTEG_DIV;
            end
            ST_INTEG_DIV: begin
                cmd.div_sel = DIV_INTEG;
                if (sts.div_done) begin
                    cmd.add_quot = 1'b1;
                    state_next   = ST_DERIV_SPAN;
                end
            end
            ST_DERIV_SPAN: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DERIV_SPAN;
                state_next  = ST_DERIV_MUL;
            end
            ST_DERIV_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DERIV;
                state_next  = ST_DERIV_GO;
            end
            ST_DERIV_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DERIV;
                state_next    = ST_DERIV_DIV;
            end
            ST_DERIV_DIV: begin
                cmd.div_sel = DIV_DERIV;
                if (sts.div_done) begin
                    cmd.add_quot = 1'b1;
                    state_next   = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;

endmodule

/* design/incremental_pid_controller_top.sv */
// Incremental PID controller with input range scaling and output clamp.
//
// One raw sample enters on the s_axis stream per control tick; one result
// (drive, scaled reading, error) leaves on the m_axis stream for each.
// Gains, period, setpoint and input range are set through the cfg write
// port (cfg_we, cfg_index, cfg_wdata); the user must do so only while no
// sample is in flight, since the block itself does not enforce it.
// One sample is processed at a time; s_axis_tready is high only while the
// controller waits for a sample. With an empty input range the raw reading
// becomes the scaled reading; otherwise the bit-serial divider forms it
// with 20 quotient bits. The same divider forms the derivative term with
// 56 quotient bits. The integral term divides by 2000 with a reciprocal
// multiply, three digits, each a multiply step and a remainder step.
// The result sits in an output register, so the next sample is accepted
// while an earlier result waits; if the receiver stalls, the new result is
// held back until the output register frees up.
// aresetn (synchronous, active low) restores default configuration, clears
// the previous error and the accumulated output, and drops m_axis_tvalid.
module incremental_pid_controller_top import ipid_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // [9:0] raw_sample
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [9:0] drive, [21:10] scaled_reading, [34:22] error_value
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    ipid_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ipid_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    ipid_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg         (cfg),
        .raw_sample  (s_axis_tdata[SAMPLE_W-1:0]),
        .sts         (sts),
        .result_data (m_axis_tdata)
    );

endmodule

/* design/ipid_checker.sv */
// Port-level checks for the incremental PID controller, bound to the top level.
module ipid_checker import ipid_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready
);

    logic signed [SPAN_W-1:0] err_plus_scaled;

    // error + scaled reading gives back the setpoint
    assign err_plus_scaled =
        SPAN_W'($signed(m_axis_tdata[OUT_ERR_LSB +: ERR_W])) +
        SPAN_W'($signed(m_axis_tdata[OUT_SCALED_LSB +: SCALED_W]));

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transaction changed while stalled");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not return to idle");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample accepted while one in flight");

    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("controller not idle after result handoff");

    a_error_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> err_plus_scaled >= 0 && err_plus_scaled <= FULL_SCALE)
        else $error("error and scaled reading disagree");

endmodule

bind incremental_pid_controller_top ipid_checker u_ipid_checker (.*);
